/* hdl/midi_echo_suppression_queue_top_assert.svh */
// assertion macros for the echo suppression queue
`ifndef MIDI_ECHO_SUPPRESSION_QUEUE_TOP_ASSERT_SVH
`define MIDI_ECHO_SUPPRESSION_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MESQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MESQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define MESQ_ASSERT(lbl, clk, rst_n, prop, msg)

`define MESQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* hdl/mesq_pkg.sv */
// types, constants and register codes of the echo suppression queue
`timescale 1ns / 1ps

package mesq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_GUARD_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_RETURN_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_WINDOW_MS      = 2'd2;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    typedef logic [TIME_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [2:0] msg_type;
        logic [4:0] msg_channel;
        logic [6:0] first_byte;
        logic [6:0] second_byte;
        t_word      expiry;
    } t_entry;

    // result of the shared add / subtract unit
    typedef struct packed {
        t_word sum;
        logic  positive;
    } t_alu_res;

endpackage

/* hdl/mesq_addsub.sv */
// shared 32-bit add / subtract unit with signed-positive flag
`timescale 1ns / 1ps

module mesq_addsub (
    input  mesq_pkg::t_word    i_a,
    input  mesq_pkg::t_word    i_b,
    input  logic               i_sub,
    output mesq_pkg::t_alu_res o_res
);
    import mesq_pkg::*;

    t_word w_b;
    t_word w_sum;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign w_sum = i_a + w_b + t_word'(i_sub);

    // wrap-safe order: strictly after when the difference is positive as signed
    assign o_res.sum      = w_sum;
    assign o_res.positive = (w_sum != '0) && !w_sum[TIME_W-1];

endmodule

/* hdl/midi_echo_suppression_queue_top.sv */
// echo suppression queue: ring of sent messages with expiry, sequenced check
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_ready  | action, msg_type, msg_channel, bytes, now
//  result  | out       | o_valid / i_ready  | is_echo, pending_count
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// one item at a time: an inert item goes straight to the result register, a record first writes
// the ring, and a check reads the head and evaluates it, popping each expired entry and reading again,
// using the one shared add / subtract unit
// reset is synchronous active low and empties the ring; ring contents are not cleared
// a result waiting on the output does not block the next input transfer
`timescale 1ns / 1ps

`include "midi_echo_suppression_queue_top_assert.svh"

module midi_echo_suppression_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [2:0]  i_msg_type,
    input  logic [4:0]  i_msg_channel,
    input  logic [6:0]  i_first_byte,
    input  logic [6:0]  i_second_byte,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_echo,
    output logic [4:0]  o_pending_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    import mesq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REC  = 5'b00010,
        S_READ = 5'b00100,
        S_EVAL = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic        r_guard_enable;
    logic [4:0]  r_return_channel;
    logic [15:0] r_window_ms;

    // captured item
    logic        r_action;
    logic [2:0]  r_msg_type;
    logic [4:0]  r_msg_channel;
    logic [6:0]  r_first_byte;
    logic [6:0]  r_second_byte;
    t_word       r_now;

    // ring control
    t_idx  r_head, n_head;
    t_cnt  r_fill, n_fill;
    t_word r_hit_total, n_hit_total;
    logic  r_echo, n_echo;

    // ring storage
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_entry;

    // output register
    logic r_out_valid;
    logic r_out_echo;
    t_cnt r_out_count;

    logic     w_accept;
    logic     w_active;
    logic     w_full;
    logic     w_load_out;
    logic     w_match;
    logic     w_wr_en;
    t_idx     w_head_inc;
    t_idx     w_rec_head;
    t_idx     w_tail;
    logic [IDX_W:0] w_tail_sum;
    t_entry   w_wr_entry;
    t_word    w_alu_b;
    logic     w_alu_sub;
    t_alu_res w_alu;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_active = r_guard_enable && (i_msg_channel == r_return_channel);
    assign w_full   = (r_fill == t_cnt'(QUEUE_DEPTH));
    assign w_head_inc = (r_head == t_idx'(QUEUE_DEPTH - 1)) ? '0 : r_head + t_idx'(1);

    // tail slot after a possible eviction of the oldest entry
    assign w_rec_head = w_full ? w_head_inc : r_head;
    assign w_tail_sum = {1'b0, w_rec_head} + (IDX_W + 1)'(w_full ? r_fill - t_cnt'(1) : r_fill);
    assign w_tail     = (w_tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
                      ? t_idx'(w_tail_sum - (IDX_W + 1)'(QUEUE_DEPTH))
                      : w_tail_sum[IDX_W-1:0];

    assign w_match = (r_rd_entry.msg_type == r_msg_type)
                  && (r_rd_entry.msg_channel == r_msg_channel)
                  && (r_rd_entry.first_byte == r_first_byte)
                  && (r_rd_entry.second_byte == r_second_byte);

    // shared unit: now + window on record, now - expiry on check
    assign w_alu_sub = (r_state != S_REC);
    assign w_alu_b   = w_alu_sub ? r_rd_entry.expiry : t_word'(r_window_ms);

    mesq_addsub u_addsub (
        .i_a   (r_now),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu)
    );

    assign w_wr_en = (r_state == S_REC);
    always_comb begin
        w_wr_entry.msg_type    = r_msg_type;
        w_wr_entry.msg_channel = r_msg_channel;
        w_wr_entry.first_byte  = r_first_byte;
        w_wr_entry.second_byte = r_second_byte;
        w_wr_entry.expiry      = w_alu.sum;
    end

    assign w_load_out = (r_state == S_PUSH) && (!r_out_valid || i_ready);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_hit_total = r_hit_total;
        n_echo      = r_echo;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_echo = 1'b0;
                    if (!w_active) begin
                        n_state = S_PUSH;
                    end else if (i_action == ACT_RECORD) begin
                        n_state = S_REC;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_REC: begin
                n_head  = w_rec_head;
                n_fill  = w_full ? r_fill : r_fill + t_cnt'(1);
                n_state = S_PUSH;
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                priority if (r_fill == '0) begin
                    n_state = S_PUSH;
                end else if (w_alu.positive) begin
                    // expired head: pop and look at the next one
                    n_head  = w_head_inc;
                    n_fill  = r_fill - t_cnt'(1);
                    n_state = S_READ;
                end else if (w_match) begin
                    n_head      = w_head_inc;
                    n_fill      = r_fill - t_cnt'(1);
                    n_hit_total = r_hit_total + t_word'(1);
                    n_echo      = 1'b1;
                    n_state     = S_PUSH;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_head           <= '0;
            r_fill           <= '0;
            r_hit_total      <= '0;
            r_echo           <= 1'b0;
            r_out_valid      <= 1'b0;
            r_guard_enable   <= 1'b0;
            r_return_channel <= 5'd1;
            r_window_ms      <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_hit_total <= n_hit_total;
            r_echo      <= n_echo;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GUARD_ENABLE:   r_guard_enable   <= i_cfg_wdata[0];
                    CFG_RETURN_CHANNEL: r_return_channel <= i_cfg_wdata[4:0];
                    CFG_WINDOW_MS:      r_window_ms      <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action      <= i_action;
            r_msg_type    <= i_msg_type;
            r_msg_channel <= i_msg_channel;
            r_first_byte  <= i_first_byte;
            r_second_byte <= i_second_byte;
            r_now         <= i_now_ms;
        end
        if (w_load_out) begin
            r_out_echo  <= r_echo;
            r_out_count <= r_fill;
        end
    end

    // ring memory, read at the head every cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_tail] <= w_wr_entry;
        end
        r_rd_entry <= r_mem[r_head];
    end

    assign o_valid         = r_out_valid;
    assign o_is_echo       = r_out_echo;
    assign o_pending_count = 5'(r_out_count);

    `MESQ_ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > t_cnt'(QUEUE_DEPTH), "ring fill above depth")
    `MESQ_ASSERT(a_hit_counts, i_clk, i_rst_n, (r_state == S_EVAL && r_fill != '0 && !w_alu.positive && w_match) |=> (r_hit_total == $past(r_hit_total) + t_word'(1)) && r_echo, "echo without hit count")
    `MESQ_ASSERT(a_head_still, i_clk, i_rst_n, (r_state == S_IDLE || r_state == S_READ || r_state == S_PUSH) |=> $stable(r_head), "head moved outside pop or record")
    `MESQ_ASSERT(a_count_shown, i_clk, i_rst_n, w_load_out |=> o_valid && (o_pending_count == 5'($past(r_fill))), "result count differs from ring fill")
    `MESQ_ASSERT_NEVER(a_record_echo, i_clk, i_rst_n, w_load_out && r_echo && (r_action == ACT_RECORD), "echo reported for a record item")

endmodule

/* bench/testbench.sv */
// testbench for the echo suppression queue: directed cases, then random record and check traffic
`timescale 1ns / 1ps

module testbench;

    import mesq_pkg::*;

    localparam int CLK_PERIOD = 8;

    typedef struct packed {
        logic       action;
        logic [2:0] msg_type;
        logic [4:0] msg_channel;
        logic [6:0] first_byte;
        logic [6:0] second_byte;
        t_word      now_ms;
    } t_midi_item;

    typedef struct packed {
        logic       is_echo;
        logic [4:0] pending_count;
    } t_echo_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = ACT_RECORD;
    logic [2:0]  i_msg_type = '0;
    logic [4:0]  i_msg_channel = '0;
    logic [6:0]  i_first_byte = '0;
    logic [6:0]  i_second_byte = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_is_echo;
    logic [4:0]  o_pending_count;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_GUARD_ENABLE;
    logic [15:0] i_cfg_wdata = '0;

    midi_echo_suppression_queue_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_msg_type      (i_msg_type),
        .i_msg_channel   (i_msg_channel),
        .i_first_byte    (i_first_byte),
        .i_second_byte   (i_second_byte),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_is_echo       (o_is_echo),
        .o_pending_count (o_pending_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // shadow of the block's registers and ring
    logic        cfg_guard = 1'b0;
    logic [4:0]  cfg_channel = 5'd1;
    logic [15:0] cfg_window = '0;
    t_entry      echo_ring [QUEUE_DEPTH];
    t_idx        ring_head = '0;
    int          ring_fill = 0;
    logic [31:0] echo_hits = '0;

    t_echo_res   echo_expect_q[$];
    t_echo_res   want;
    t_midi_item  sent_log[$];
    t_word       clock_ms = '0;
    logic        idle_on = 1'b1;
    int          rx_hold = 0;
    int          n_errors = 0;
    int          n_records = 0;
    int          n_checks = 0;
    int          n_inert = 0;
    int          n_evicted = 0;
    int          n_expired = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("** midi_echo_suppression_queue_top: FAILED **");
        $finish;
    end

    function automatic void drop_oldest();
        ring_head = t_idx'((ring_head + 1) % QUEUE_DEPTH);
        ring_fill = ring_fill - 1;
    endfunction

    function automatic t_echo_res predict_echo(input t_midi_item m);
        t_echo_res r;
        t_idx      tail;
        t_entry    hd;
        r.is_echo = 1'b0;
        if (cfg_guard && m.msg_channel == cfg_channel) begin
            if (m.action == ACT_RECORD) begin
                n_records++;
                if (ring_fill >= QUEUE_DEPTH) begin
                    drop_oldest();
                    n_evicted++;
                end
                tail = t_idx'((ring_head + ring_fill) % QUEUE_DEPTH);
                echo_ring[tail].msg_type    = m.msg_type;
                echo_ring[tail].msg_channel = m.msg_channel;
                echo_ring[tail].first_byte  = m.first_byte;
                echo_ring[tail].second_byte = m.second_byte;
                echo_ring[tail].expiry      = m.now_ms + cfg_window;
                ring_fill = ring_fill + 1;
            end else begin
                n_checks++;
                // wrap-safe: expired once now lies strictly after the expiry
                while (ring_fill > 0 &&
                       $signed(m.now_ms - echo_ring[ring_head].expiry) > 0) begin
                    drop_oldest();
                    n_expired++;
                end
                if (ring_fill > 0) begin
                    hd = echo_ring[ring_head];
                    if (hd.msg_type == m.msg_type && hd.msg_channel == m.msg_channel &&
                        hd.first_byte == m.first_byte && hd.second_byte == m.second_byte) begin
                        drop_oldest();
                        echo_hits = echo_hits + 1;
                        r.is_echo = 1'b1;
                    end
                end
            end
        end else begin
            n_inert++;
        end
        r.pending_count = ring_fill[4:0];
        return r;
    endfunction

    // result side: random stalls drawn per transfer
    always @(posedge i_clk) begin
        if (o_valid && i_ready)
            rx_hold = idle_on ? $urandom_range(0, 3) : 0;
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (echo_expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: result with nothing expected: is_echo %0b pending %0d",
                             $realtime, o_is_echo, o_pending_count);
            end else begin
                want = echo_expect_q.pop_front();
                if (o_is_echo !== want.is_echo || o_pending_count !== want.pending_count) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: mismatch: is_echo exp %0b got %0b, pending exp %0d got %0d",
                                 $realtime, want.is_echo, o_is_echo,
                                 want.pending_count, o_pending_count);
                end
            end
        end
    end

    task automatic send_item(input t_midi_item m);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= m.action;
        i_msg_type    <= m.msg_type;
        i_msg_channel <= m.msg_channel;
        i_first_byte  <= m.first_byte;
        i_second_byte <= m.second_byte;
        i_now_ms      <= m.now_ms;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        echo_expect_q.push_back(predict_echo(m));
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (echo_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_GUARD_ENABLE:   cfg_guard = val[0];
            CFG_RETURN_CHANNEL: cfg_channel = val[4:0];
            CFG_WINDOW_MS:      cfg_window = val;
            default: ;
        endcase
    endtask

    task automatic set_guard(input logic en, input logic [4:0] chan, input logic [15:0] win);
        wait_results();
        sent_log.delete();
        write_reg(CFG_GUARD_ENABLE, {15'd0, en});
        write_reg(CFG_RETURN_CHANNEL, {11'd0, chan});
        write_reg(CFG_WINDOW_MS, win);
    endtask

    function automatic t_midi_item make_item(input logic act, input logic [2:0] kind,
                                             input logic [4:0] chan, input logic [6:0] b1,
                                             input logic [6:0] b2, input t_word now);
        t_midi_item m;
        m.action = act;
        m.msg_type = kind;
        m.msg_channel = chan;
        m.first_byte = b1;
        m.second_byte = b2;
        m.now_ms = now;
        return m;
    endfunction

    task automatic advance_clock();
        case ($urandom_range(0, 39))
            0: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
            1: clock_ms = $urandom();
            2: clock_ms = clock_ms + cfg_window + $urandom_range(1, 500);
            3: clock_ms = clock_ms - $urandom_range(1, 20);
            default: begin
                if ($urandom_range(0, 2) != 0)
                    clock_ms = clock_ms + $urandom_range(0, cfg_window / 6 + 2);
            end
        endcase
    endtask

    function automatic t_midi_item random_item(input logic act);
        t_midi_item m;
        m.action = act;
        m.msg_type = 3'($urandom_range(0, 7));
        m.msg_channel = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : cfg_channel;
        m.first_byte = 7'($urandom_range(0, 127));
        m.second_byte = 7'($urandom_range(0, 127));
        m.now_ms = clock_ms;
        return m;
    endfunction

    // bursts of outgoing records followed by mostly matching returns
    task automatic run_traffic(input int n_target);
        int         start;
        int         burst;
        t_midi_item m;
        start = n_records + n_checks + n_inert;
        while (n_records + n_checks + n_inert - start < n_target) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                advance_clock();
                m = random_item(ACT_RECORD);
                send_item(m);
                if (m.msg_channel == cfg_channel) sent_log.push_back(m);
                if (sent_log.size() > 32) void'(sent_log.pop_front());
            end
            repeat ($urandom_range(1, burst + 2)) begin
                advance_clock();
                m = random_item(ACT_CHECK);
                if (sent_log.size() != 0 && $urandom_range(0, 9) < 8) begin
                    m.msg_type    = sent_log[0].msg_type;
                    m.msg_channel = sent_log[0].msg_channel;
                    m.first_byte  = sent_log[0].first_byte;
                    m.second_byte = sent_log[0].second_byte;
                    // near miss on one velocity bit
                    if ($urandom_range(0, 9) == 0)
                        m.second_byte[3'($urandom_range(0, 6))] ^= 1'b1;
                    void'(sent_log.pop_front());
                end
                send_item(m);
            end
            if ($urandom_range(0, 7) == 0) wait_results();
        end
    endtask

    task automatic test_guard_disabled();
        send_item(make_item(ACT_CHECK, 3'd2, 5'd1, 7'd64, 7'd100, 32'd0));
    endtask

    task automatic test_window_zero();
        set_guard(1'b1, 5'd1, 16'd0);
        // live only while now equals the record time
        send_item(make_item(ACT_RECORD, 3'd7, 5'd1, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_item(make_item(ACT_CHECK, 3'd7, 5'd1, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_item(make_item(ACT_RECORD, 3'd0, 5'd1, 7'd0, 7'd0, 32'd100));
        send_item(make_item(ACT_CHECK, 3'd0, 5'd1, 7'd0, 7'd0, 32'd101));
    endtask

    task automatic test_other_channel();
        send_item(make_item(ACT_RECORD, 3'd5, 5'd31, 7'd10, 7'd20, 32'd200));
        send_item(make_item(ACT_RECORD, 3'd5, 5'd0, 7'd10, 7'd20, 32'd200));
    endtask

    task automatic test_ring_full();
        set_guard(1'b1, 5'd16, 16'hFFFF);
        // expiry sums wrap past zero; the seventeenth record evicts the first
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_item(make_item(ACT_RECORD, 3'(i), 5'd16, 7'(i), 7'(127 - i), 32'hFFFF_FFF0));
        send_item(make_item(ACT_CHECK, 3'd0, 5'd16, 7'd0, 7'd127, 32'hFFFF_FFF8));
        send_item(make_item(ACT_CHECK, 3'd1, 5'd16, 7'd1, 7'd126, 32'h0000_1000));
        send_item(make_item(ACT_CHECK, 3'd2, 5'd16, 7'd2, 7'd125, 32'h0001_0000));
    endtask

    task automatic test_unused_index();
        wait_results();
        write_reg(2'd3, 16'($urandom()));
        send_item(make_item(ACT_RECORD, 3'd4, 5'd16, 7'd33, 7'd44, 32'h0001_0000));
    endtask

    task automatic test_random_traffic();
        set_guard(1'b1, 5'd10, 16'd60);
        run_traffic(300);
        set_guard(1'b1, 5'd1, 16'd0);
        run_traffic(200);
        // a stretch without idling on either side
        idle_on = 1'b0;
        set_guard(1'b1, 5'd16, 16'hFFFF);
        run_traffic(200);
        idle_on = 1'b1;
        set_guard(1'b1, 5'd0, 16'd300);
        run_traffic(150);
        set_guard(1'b1, 5'd31, 16'($urandom_range(1, 2000)));
        run_traffic(150);
    endtask

    task automatic test_guard_off();
        set_guard(1'b0, 5'd5, 16'd100);
        run_traffic(80);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_guard_disabled();
        test_window_zero();
        test_other_channel();
        test_ring_full();
        test_unused_index();
        test_random_traffic();
        test_guard_off();
        wait_results();
        repeat (50) @(posedge i_clk);
        $display("covered %0d records, %0d checks and %0d inert items; %0d echoes matched",
                 n_records, n_checks, n_inert, echo_hits);
        $display("ring evictions %0d, expired entries dropped %0d, failures %0d",
                 n_evicted, n_expired, n_errors);
        if (n_errors == 0)
            $display("** midi_echo_suppression_queue_top: PASSED **");
        else
            $display("** midi_echo_suppression_queue_top: FAILED **");
        $finish;
    end

endmodule
